FILE: rtl/core/fatlc_pkg.sv
// Shared constants and codes for the FAT location classifier.
package fatlc_pkg;

  localparam int LOCATION_BITS_DEF = 42;
  localparam int SECTOR_BITS       = 42;
  localparam int CLUSTER_BITS      = 32;
  localparam int BPS_W             = 13;
  localparam int SPC_W             = 8;
  localparam int RSV_W             = 16;
  localparam int SEC32_W           = 32;
  localparam int DCL_W             = 28;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int KB_SHIFT          = 10;
  localparam int FIRST_CLUSTER     = 2;
  localparam int DIV_STEP          = 4;
  localparam int OUT_USER_W        = 3;
  localparam int OUT_DW            = ((SECTOR_BITS + CLUSTER_BITS + 7) / 8) * 8;

  localparam logic [BPS_W-1:0] BPS_RST = BPS_W'(512);
  localparam logic [SPC_W-1:0] SPC_RST = SPC_W'(1);
  localparam logic [RSV_W-1:0] RSV_RST = RSV_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPS         = 3'd0,
    CFG_SPC         = 3'd1,
    CFG_RESERVED    = 3'd2,
    CFG_FAT_END     = 3'd3,
    CFG_DATA_START  = 3'd4,
    CFG_DATA_CLUST  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    UNIT_SECTOR  = 2'd0,
    UNIT_CLUSTER = 2'd1,
    UNIT_BYTE    = 2'd2,
    UNIT_KBLOCK  = 2'd3
  } unit_kind_t;

  typedef enum logic [1:0] {
    REG_RESERVED = 2'd0,
    REG_FAT      = 2'd1,
    REG_ROOT     = 2'd2,
    REG_DATA     = 2'd3
  } region_t;

endpackage

FILE: rtl/core/fat_location_classifier_top.sv
// The first divider works on DIV_W = min(LOCATION_BITS+10, 64) bits.
// Throughput: one transaction per cycle unless out_tready is low and every stage is full;
//   each divider retires 4 quotient bits per stage.
// Stages with a bubble take a new item even while the output waits.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default geometry.
module fat_location_classifier_top import fatlc_pkg::*; #(
  parameter int LOCATION_BITS = LOCATION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [CFG_DATA_W-1:0]                cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((LOCATION_BITS+7)/8)*8-1:0]   in_tdata,   // location
  input  logic [1:0]                           in_tuser,   // unit_kind
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [OUT_DW-1:0]                    out_tdata,  // sector_number, data_cluster
  output logic [OUT_USER_W-1:0]                out_tuser   // region, data_area_flag
);

  localparam int LB     = LOCATION_BITS;
  localparam int EXT_W  = LB + KB_SHIFT;
  localparam int DIV_W  = (EXT_W > 64) ? 64 : EXT_W;
  localparam int PW     = LB + SPC_W;
  localparam int N1     = (DIV_W + DIV_STEP - 1) / DIV_STEP;
  localparam int N2     = (SECTOR_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int S_A    = 1;
  localparam int S_D1   = 2;
  localparam int S_B    = S_D1 + N1;
  localparam int S_C    = S_B + 1;
  localparam int S_D2   = S_C + 1;
  localparam int S_F    = S_D2 + N2;
  localparam int NST    = S_F + 1;
  localparam logic [SECTOR_BITS-1:0] SMAX = '1;

  typedef struct packed {
    logic [LB-1:0]          loc;
    unit_kind_t             kind;
    logic                   cl_ge2;
    logic                   cl_in;
    logic [PW-1:0]          prod;
    logic [SECTOR_BITS-1:0] sec;
    logic [DIV_W-1:0]       num1;
    logic [BPS_W-1:0]       rem1;
    region_t                region;
    logic                   in_data;
    logic [SECTOR_BITS-1:0] num2;
    logic [SPC_W-1:0]       rem2;
    logic [CLUSTER_BITS-1:0] cluster;
  } stage_t;

  // geometry registers
  logic [BPS_W-1:0]   bps_r;
  logic [SPC_W-1:0]   spc_r;
  logic [RSV_W-1:0]   rsv_r;
  logic [SEC32_W-1:0] fat_end_r;
  logic [SEC32_W-1:0] dstart_r;
  logic [DCL_W-1:0]   dclust_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r     <= BPS_RST;
      spc_r     <= SPC_RST;
      rsv_r     <= RSV_RST;
      fat_end_r <= '0;
      dstart_r  <= '0;
      dclust_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BPS:        bps_r     <= cfg_wdata[BPS_W-1:0];
        CFG_SPC:        spc_r     <= cfg_wdata[SPC_W-1:0];
        CFG_RESERVED:   rsv_r     <= cfg_wdata[RSV_W-1:0];
        CFG_FAT_END:    fat_end_r <= cfg_wdata[SEC32_W-1:0];
        CFG_DATA_START: dstart_r  <= cfg_wdata[SEC32_W-1:0];
        CFG_DATA_CLUST: dclust_r  <= cfg_wdata[DCL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [BPS_W-1:0] bps_eff;
  logic [SPC_W-1:0] spc_eff;
  assign bps_eff = (bps_r == '0) ? BPS_W'(1) : bps_r;
  assign spc_eff = (spc_r == '0) ? SPC_W'(1) : spc_r;

  stage_t         st_r   [NST];
  stage_t         st_nxt [NST];
  logic [NST-1:0] vld_r;
  logic [NST:0]   rdy;

  // a stage takes a new item when it is empty or its item moves on
  always_comb begin
    rdy[NST] = out_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end
  assign in_tready = rdy[0];

  always_comb begin
    stage_t              cur;
    logic [EXT_W-1:0]    ext;
    logic [DIV_W-1:0]    div_in;
    logic [DCL_W:0]      dc_lim;
    logic [PW:0]         ssum;
    logic [DIV_W-1:0]    q1;
    logic [BPS_W:0]      t1;
    logic [SPC_W:0]      t2;
    logic [SECTOR_BITS:0] csum;
    for (int k = 0; k < NST; k++) begin
      ext    = '0;
      div_in = '0;
      dc_lim = '0;
      ssum   = '0;
      q1     = '0;
      t1     = '0;
      t2     = '0;
      csum   = '0;
      if (k == 0) begin
        cur      = '0;
        cur.loc  = in_tdata[LB-1:0];
        cur.kind = unit_kind_t'(in_tuser);
      end else begin
        cur = st_r[k-1];
        if (k == S_A) begin
          ext    = {cur.loc, {KB_SHIFT{1'b0}}};
          div_in = (cur.kind == UNIT_KBLOCK) ?
                   (((ext >> DIV_W) != '0) ? '1 : DIV_W'(ext)) : DIV_W'(cur.loc);
          cur.num1   = div_in;
          cur.rem1   = '0;
          cur.cl_ge2 = cur.loc >= LB'(FIRST_CLUSTER);
          dc_lim     = {1'b0, dclust_r} + (DCL_W+1)'(FIRST_CLUSTER);
          cur.cl_in  = cur.loc < LB'(dc_lim);
          cur.prod   = PW'(cur.loc - LB'(FIRST_CLUSTER)) * PW'(spc_eff);
          cur.sec    = ((cur.loc >> SECTOR_BITS) != '0) ? SMAX : SECTOR_BITS'(cur.loc);
        end else if (k >= S_D1 && k < S_B) begin
          for (int j = 0; j < DIV_STEP; j++) begin
            if ((k - S_D1) * DIV_STEP + j < DIV_W) begin
              t1 = {cur.rem1, cur.num1[DIV_W-1]};
              cur.num1 = {cur.num1[DIV_W-2:0], 1'b0};
              if (t1 >= {1'b0, bps_eff}) begin
                t1 = t1 - {1'b0, bps_eff};
                cur.num1[0] = 1'b1;
              end
              cur.rem1 = t1[BPS_W-1:0];
            end
          end
        end else if (k == S_B) begin
          ssum = PW'(dstart_r) + {1'b0, cur.prod};
          q1   = cur.num1;
          unique case (cur.kind)
            UNIT_SECTOR:  cur.sec = cur.sec;
            UNIT_CLUSTER: cur.sec = !cur.cl_ge2 ? '0 :
                                    (((ssum >> SECTOR_BITS) != '0) ? SMAX :
                                     SECTOR_BITS'(ssum));
            default:      cur.sec = ((q1 >> SECTOR_BITS) != '0) ? SMAX :
                                    SECTOR_BITS'(q1);
          endcase
        end else if (k == S_C) begin
          priority if (cur.sec < SECTOR_BITS'(rsv_r))     cur.region = REG_RESERVED;
          else if (cur.sec < SECTOR_BITS'(fat_end_r))     cur.region = REG_FAT;
          else if (cur.sec < SECTOR_BITS'(dstart_r))      cur.region = REG_ROOT;
          else                                            cur.region = REG_DATA;
          cur.in_data = (cur.kind == UNIT_CLUSTER) ? (cur.cl_ge2 && cur.cl_in) :
                        (cur.sec >= SECTOR_BITS'(dstart_r));
          cur.num2 = cur.sec - SECTOR_BITS'(dstart_r);
          cur.rem2 = '0;
        end else if (k >= S_D2 && k < S_F) begin
          for (int j = 0; j < DIV_STEP; j++) begin
            if ((k - S_D2) * DIV_STEP + j < SECTOR_BITS) begin
              t2 = {cur.rem2, cur.num2[SECTOR_BITS-1]};
              cur.num2 = {cur.num2[SECTOR_BITS-2:0], 1'b0};
              if (t2 >= {1'b0, spc_eff}) begin
                t2 = t2 - {1'b0, spc_eff};
                cur.num2[0] = 1'b1;
              end
              cur.rem2 = t2[SPC_W-1:0];
            end
          end
        end else begin
          csum = {1'b0, cur.num2} + (SECTOR_BITS+1)'(FIRST_CLUSTER);
          if (cur.region != REG_DATA)              cur.cluster = '0;
          else if ((csum >> CLUSTER_BITS) != '0)   cur.cluster = '1;
          else                                     cur.cluster = CLUSTER_BITS'(csum);
        end
      end
      st_nxt[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k] && ((k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k-1])) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {{(OUT_DW-SECTOR_BITS-CLUSTER_BITS){1'b0}},
                       st_r[NST-1].cluster, st_r[NST-1].sec};
  assign out_tuser  = {st_r[NST-1].in_data, st_r[NST-1].region};

  // Assertions
  a_cluster_zero_outside_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != REG_DATA) |->
      out_tdata[SECTOR_BITS +: CLUSTER_BITS] == '0)
    else $error("data cluster nonzero outside the data area");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (vld_r == '1) && !out_tready)
    else $error("input stalled while the pipeline has a bubble");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_data_region_sector: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == REG_DATA) |->
      out_tdata[SECTOR_BITS-1:0] >= SECTOR_BITS'(dstart_r))
    else $error("data region below data start");

endmodule
